[rtl/rhls_pkg.sv]
// ----------------------------------------------------------------------------
// rhls_pkg
// Shared widths, constants and stage-to-stage types of the RGB to HLS core.
// ----------------------------------------------------------------------------
package rhls_pkg;

    localparam int CH_W  = 8;   // one color channel
    localparam int HUE_W = 9;   // hue in degrees
    localparam int PCT_W = 7;   // lightness and saturation in percent
    localparam int HN_W  = 18;  // hue dividend: 2*|num| + d
    localparam int HD_W  = 9;   // hue divisor: 2*d
    localparam int SN_W  = 23;  // saturation dividend: 20000*d + 255*den
    localparam int SD_W  = 16;  // saturation divisor: 510*den
    localparam int Q_W   = 9;   // quotient bits, one per divider stage

    localparam logic [HUE_W-1:0] HUE_WRAP = HUE_W'(360);
    localparam logic [HUE_W-1:0] HUE_MAX  = HUE_W'(359);
    localparam logic [PCT_W-1:0] PCT_MAX  = PCT_W'(100);

    typedef struct packed {
        logic             neg;
        logic             grey;
        logic             ovf;
        logic [PCT_W-1:0] l;
    } side_t;

    typedef struct packed {
        logic [HN_W-1:0] hn;
        logic [HD_W-1:0] hd;
        logic [SN_W-1:0] sn;
        logic [SD_W-1:0] sd;
    } lanes_t;

    typedef struct packed {
        logic [Q_W-1:0] hq;
        logic [Q_W-1:0] sq;
        side_t          side;
    } div_res_t;

endpackage

[rtl/rhls_front.sv]
// ----------------------------------------------------------------------------
// rhls_front
// Six-stage front end: max/min, hue numerator, lightness by reciprocal
// multiply, saturation denominator and the saturation overflow check.
// ----------------------------------------------------------------------------
module rhls_front
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      pixel_valid,
    output logic                      pixel_ready,
    input  logic [rhls_pkg::CH_W-1:0] red,
    input  logic [rhls_pkg::CH_W-1:0] green,
    input  logic [rhls_pkg::CH_W-1:0] blue,
    output logic                      dv_valid,
    input  logic                      dv_ready,
    output rhls_pkg::lanes_t          dv_lanes,
    output rhls_pkg::side_t           dv_side
);
    import rhls_pkg::*;

    localparam int NST = 6;

    typedef enum logic [1:0] {SEC_RED, SEC_GREEN, SEC_BLUE} sector_t;

    logic [NST-1:0] vld_reg;
    logic [NST-1:0] en;

    // stage 1
    sector_t            sec1_reg, sec1_next;
    logic signed [8:0]  diff1_reg, diff1_next;
    logic [CH_W-1:0]    d1_reg, d1_next;
    logic [8:0]         sum1_reg, sum1_next;
    logic [CH_W-1:0]    mx, mn;
    // stage 2
    logic signed [17:0] hnum2_reg, hnum2_next;
    logic [CH_W-1:0]    d2_reg;
    logic               grey2_reg, neg2_reg, neg2_next;
    logic [14:0]        y2_reg, y2_next;
    logic [17:0]        off_d;
    logic signed [17:0] diff60;
    logic [16:0]        x2;
    // stage 3
    logic [HN_W-1:0]    hn3_reg, hn3_next;
    logic [CH_W-1:0]    d3_reg;
    logic               grey3_reg, neg3_reg;
    logic [14:0]        y3_reg;
    logic [PCT_W-1:0]   q3_reg, q3_next;
    logic [16:0]        habs;
    logic [22:0]        prod;
    // stage 4
    logic [HN_W-1:0]    hn4_reg;
    logic [CH_W-1:0]    d4_reg;
    logic               grey4_reg, neg4_reg;
    logic [PCT_W-1:0]   l4_reg, l4_next;
    logic [14:0]        rem;
    // stage 5
    logic [HN_W-1:0]    hn5_reg;
    logic [CH_W-1:0]    d5_reg;
    logic               grey5_reg, neg5_reg;
    logic [PCT_W-1:0]   l5_reg;
    logic [SN_W-1:0]    sn5_reg, sn5_next;
    logic [SD_W-1:0]    sd5_reg, sd5_next;
    logic [7:0]         tw, dev;
    logic [PCT_W-1:0]   den;
    // stage 6
    lanes_t             lanes6_reg;
    side_t              side6_reg, side6_next;

    always_comb
    begin
        en[NST-1] = !vld_reg[NST-1] || dv_ready;
        for (int i = NST - 2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    assign pixel_ready = en[0];
    assign dv_valid    = vld_reg[NST-1];
    assign dv_lanes    = lanes6_reg;
    assign dv_side     = side6_reg;

    always_comb
    begin
        if (red >= green && red >= blue)
        begin
            sec1_next  = SEC_RED;
            mx         = red;
            diff1_next = $signed({1'b0, green}) - $signed({1'b0, blue});
        end
        else if (green >= blue)
        begin
            sec1_next  = SEC_GREEN;
            mx         = green;
            diff1_next = $signed({1'b0, blue}) - $signed({1'b0, red});
        end
        else
        begin
            sec1_next  = SEC_BLUE;
            mx         = blue;
            diff1_next = $signed({1'b0, red}) - $signed({1'b0, green});
        end
        if (red <= green && red <= blue)
        begin
            mn = red;
        end
        else if (green <= blue)
        begin
            mn = green;
        end
        else
        begin
            mn = blue;
        end
        d1_next   = mx - mn;
        sum1_next = 9'(mx) + 9'(mn);
    end

    always_comb
    begin
        case (sec1_reg)
            SEC_GREEN: off_d = 18'(d1_reg) * 18'd120;
            SEC_BLUE:  off_d = 18'(d1_reg) * 18'd240;
            default:   off_d = '0;
        endcase
        diff60     = 18'(diff1_reg) * 18'sd60;
        hnum2_next = $signed(off_d) + diff60;
        neg2_next  = (sec1_reg == SEC_RED) && diff1_reg[8];
        x2         = 17'(sum1_reg) * 17'd200 + 17'd510;
        y2_next    = x2[16:2];
    end

    always_comb
    begin
        habs     = hnum2_reg[17] ? 17'(-hnum2_reg) : 17'(hnum2_reg);
        hn3_next = {habs, 1'b0} + 18'(d2_reg);
        prod     = {y2_reg, 8'b0} + 23'(y2_reg);
        q3_next  = prod[22:16];
    end

    always_comb
    begin
        rem     = y3_reg - 15'(q3_reg) * 15'd255;
        l4_next = q3_reg + PCT_W'(rem >= 15'd255);
    end

    always_comb
    begin
        tw       = {l4_reg, 1'b0};
        dev      = (tw >= 8'(PCT_MAX)) ? tw - 8'(PCT_MAX) : 8'(PCT_MAX) - tw;
        den      = PCT_W'(8'(PCT_MAX) - dev);
        sn5_next = 23'(d4_reg) * 23'd20000 + 23'(den) * 23'd255;
        sd5_next = 16'(den) * 16'd510;
    end

    always_comb
    begin
        side6_next.neg  = neg5_reg;
        side6_next.grey = grey5_reg;
        side6_next.l    = l5_reg;
        side6_next.ovf  = {2'b0, sn5_reg} >= {sd5_reg, 9'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = NST - 1; i > 0; i--)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
            if (en[0])
            begin
                vld_reg[0] <= pixel_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            sec1_reg  <= sec1_next;
            diff1_reg <= diff1_next;
            d1_reg    <= d1_next;
            sum1_reg  <= sum1_next;
        end
        if (en[1])
        begin
            hnum2_reg <= hnum2_next;
            d2_reg    <= d1_reg;
            grey2_reg <= (d1_reg == '0);
            neg2_reg  <= neg2_next;
            y2_reg    <= y2_next;
        end
        if (en[2])
        begin
            hn3_reg   <= hn3_next;
            d3_reg    <= d2_reg;
            grey3_reg <= grey2_reg;
            neg3_reg  <= neg2_reg;
            y3_reg    <= y2_reg;
            q3_reg    <= q3_next;
        end
        if (en[3])
        begin
            hn4_reg   <= hn3_reg;
            d4_reg    <= d3_reg;
            grey4_reg <= grey3_reg;
            neg4_reg  <= neg3_reg;
            l4_reg    <= l4_next;
        end
        if (en[4])
        begin
            hn5_reg   <= hn4_reg;
            d5_reg    <= d4_reg;
            grey5_reg <= grey4_reg;
            neg5_reg  <= neg4_reg;
            l5_reg    <= l4_reg;
            sn5_reg   <= sn5_next;
            sd5_reg   <= sd5_next;
        end
        if (en[5])
        begin
            lanes6_reg.hn <= hn5_reg;
            lanes6_reg.hd <= {d5_reg, 1'b0};
            lanes6_reg.sn <= sn5_reg;
            lanes6_reg.sd <= sd5_reg;
            side6_reg     <= side6_next;
        end
    end

endmodule

[rtl/rhls_div.sv]
// ----------------------------------------------------------------------------
// rhls_div
// Two-lane restoring divider, one quotient bit per pipeline stage, for the
// hue and saturation quotients; carries the side information alongside.
// ----------------------------------------------------------------------------
module rhls_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               dv_valid,
    output logic               dv_ready,
    input  rhls_pkg::lanes_t   dv_lanes,
    input  rhls_pkg::side_t    dv_side,
    output logic               dq_valid,
    input  logic               dq_ready,
    output rhls_pkg::div_res_t dq_res
);
    import rhls_pkg::*;

    typedef struct packed {
        logic [HN_W-1:0] hr;
        logic [HD_W-1:0] hd;
        logic [SN_W-1:0] sr;
        logic [SD_W-1:0] sd;
        logic [Q_W-1:0]  hq;
        logic [Q_W-1:0]  sq;
        side_t           side;
    } stage_t;

    stage_t         stage_reg  [Q_W];
    stage_t         stage_next [Q_W];
    logic [Q_W-1:0] vld_reg;
    logic [Q_W-1:0] en;

    always_comb
    begin
        en[Q_W-1] = !vld_reg[Q_W-1] || dq_ready;
        for (int i = Q_W - 2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    assign dv_ready     = en[0];
    assign dq_valid     = vld_reg[Q_W-1];
    assign dq_res.hq    = stage_reg[Q_W-1].hq;
    assign dq_res.sq    = stage_reg[Q_W-1].sq;
    assign dq_res.side  = stage_reg[Q_W-1].side;

    always_comb
    begin
        stage_t          src;
        logic [HN_W-1:0] trial_h;
        logic [SN_W+1:0] trial_s;
        logic            bit_h, bit_s;
        for (int i = 0; i < Q_W; i++)
        begin
            if (i == 0)
            begin
                src.hr   = dv_lanes.hn;
                src.hd   = dv_lanes.hd;
                src.sr   = dv_lanes.sn;
                src.sd   = dv_lanes.sd;
                src.hq   = '0;
                src.sq   = '0;
                src.side = dv_side;
            end
            else
            begin
                src = stage_reg[i-1];
            end
            trial_h = HN_W'(src.hd) << (Q_W - 1 - i);
            trial_s = (SN_W + 2)'(src.sd) << (Q_W - 1 - i);
            bit_h   = src.hr >= trial_h;
            bit_s   = {2'b0, src.sr} >= trial_s;
            stage_next[i]      = src;
            stage_next[i].hr   = bit_h ? src.hr - trial_h : src.hr;
            stage_next[i].sr   = bit_s ? SN_W'({2'b0, src.sr} - trial_s) : src.sr;
            stage_next[i].hq   = {src.hq[Q_W-2:0], bit_h};
            stage_next[i].sq   = {src.sq[Q_W-2:0], bit_s};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = Q_W - 1; i > 0; i--)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
            if (en[0])
            begin
                vld_reg[0] <= dv_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < Q_W; i++)
        begin
            if (en[i])
            begin
                stage_reg[i] <= stage_next[i];
            end
        end
    end

    a_grey_matches_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[Q_W-1] |-> (stage_reg[Q_W-1].side.grey == (stage_reg[Q_W-1].hd == '0)))
        else $error("grey flag out of step with hue divisor");

    a_hue_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[Q_W-1] && !stage_reg[Q_W-1].side.grey
            |-> (stage_reg[Q_W-1].hr < HN_W'(stage_reg[Q_W-1].hd)))
        else $error("hue remainder not below divisor");

    a_sat_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[Q_W-1] && !stage_reg[Q_W-1].side.ovf
            |-> (stage_reg[Q_W-1].sr < SN_W'(stage_reg[Q_W-1].sd)))
        else $error("saturation remainder not below divisor");

endmodule

[rtl/rhls_out.sv]
// ----------------------------------------------------------------------------
// rhls_out
// Output register: hue wrap and clamp, grey and overflow handling of
// saturation, and the result transfer.
// ----------------------------------------------------------------------------
module rhls_out
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       dq_valid,
    output logic                       dq_ready,
    input  rhls_pkg::div_res_t         dq_res,
    output logic                       hls_valid,
    input  logic                       hls_ready,
    output logic [rhls_pkg::HUE_W-1:0] hue,
    output logic [rhls_pkg::PCT_W-1:0] lightness,
    output logic [rhls_pkg::PCT_W-1:0] saturation
);
    import rhls_pkg::*;

    logic             vld_reg;
    logic             en;
    logic [HUE_W-1:0] hue_reg, hue_next, hue_raw;
    logic [PCT_W-1:0] lit_reg;
    logic [PCT_W-1:0] sat_reg, sat_next;

    assign en         = !vld_reg || hls_ready;
    assign dq_ready   = en;
    assign hls_valid  = vld_reg;
    assign hue        = hue_reg;
    assign lightness  = lit_reg;
    assign saturation = sat_reg;

    always_comb
    begin
        if (dq_res.side.grey)
        begin
            hue_raw = '0;
        end
        else if (dq_res.side.neg && dq_res.hq != '0)
        begin
            hue_raw = HUE_WRAP - HUE_W'(dq_res.hq);
        end
        else
        begin
            hue_raw = HUE_W'(dq_res.hq);
        end
        hue_next = (hue_raw > HUE_MAX) ? HUE_MAX : hue_raw;

        if (dq_res.side.grey)
        begin
            sat_next = '0;
        end
        else if (dq_res.side.ovf || dq_res.sq > Q_W'(PCT_MAX))
        begin
            sat_next = PCT_MAX;
        end
        else
        begin
            sat_next = dq_res.sq[PCT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= dq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hue_reg <= hue_next;
            lit_reg <= dq_res.side.l;
            sat_reg <= sat_next;
        end
    end

endmodule

[rtl/rgb_to_hls_integer_core.sv]
// ----------------------------------------------------------------------------
// rgb_to_hls_integer_core
// RGB pixel to hue, lightness and saturation, exact integer rounding.
//
//   channel   handshake                  payload
//   pixel     pixel_valid / pixel_ready  red, green, blue (8 bits each)
//   hls       hls_valid / hls_ready      hue (9), lightness (7), saturation (7)
//
// One pixel per cycle sustained while hls_ready stays high; 6 front-end
// stages, 9 divider stages at one quotient bit each, 1 output register.
// Reset clears only the stage valid bits; the data registers are not reset.
// Each stage holds while its successor is full and stalled, so a stall on
// hls_ready backs up stage by stage and bubbles are squeezed out.
// ----------------------------------------------------------------------------
module rgb_to_hls_integer_core
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       pixel_valid,
    output logic                       pixel_ready,
    input  logic [rhls_pkg::CH_W-1:0]  red,
    input  logic [rhls_pkg::CH_W-1:0]  green,
    input  logic [rhls_pkg::CH_W-1:0]  blue,
    output logic                       hls_valid,
    input  logic                       hls_ready,
    output logic [rhls_pkg::HUE_W-1:0] hue,
    output logic [rhls_pkg::PCT_W-1:0] lightness,
    output logic [rhls_pkg::PCT_W-1:0] saturation
);
    import rhls_pkg::*;

    logic     dv_valid, dv_ready;
    lanes_t   dv_lanes;
    side_t    dv_side;
    logic     dq_valid, dq_ready;
    div_res_t dq_res;

    rhls_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .dv_valid    (dv_valid),
        .dv_ready    (dv_ready),
        .dv_lanes    (dv_lanes),
        .dv_side     (dv_side)
    );

    rhls_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .dv_valid (dv_valid),
        .dv_ready (dv_ready),
        .dv_lanes (dv_lanes),
        .dv_side  (dv_side),
        .dq_valid (dq_valid),
        .dq_ready (dq_ready),
        .dq_res   (dq_res)
    );

    rhls_out u_out
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .dq_valid   (dq_valid),
        .dq_ready   (dq_ready),
        .dq_res     (dq_res),
        .hls_valid  (hls_valid),
        .hls_ready  (hls_ready),
        .hue        (hue),
        .lightness  (lightness),
        .saturation (saturation)
    );

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for rgb_to_hls_integer_core. Pixels go in over a
// valid/ready channel and every hue/lightness/saturation transfer is compared
// in order against its table value or an integer predictor of the
// conversion. A short table of directed pixels (primaries, greys, clamps,
// ties, rounding edges) comes first, followed by random pixels biased toward
// greys, ties, very dark and very bright colors. Both sides idle at random;
// the receiver once stalls long enough to back the pipe up to its input.
// ----------------------------------------------------------------------------
module testbench;

    import rhls_pkg::*;

    localparam int NUM_DIRECTED = 25;
    localparam int RANDOM_ITEMS = 1500;
    localparam int HOLD_CYCLES  = 120;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int MAX_PRINTED  = 20;

    localparam logic KNOWN     = 1'b1;
    localparam logic PREDICTED = 1'b0;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [PCT_W-1:0] lightness;
        logic [PCT_W-1:0] saturation;
    } hls_t;

    typedef struct packed {
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
        logic            typed;
        hls_t            want;
    } pixel_row_t;

    logic             clk;
    logic             rst_n;
    logic             pixel_valid;
    logic             pixel_ready;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic             hls_valid;
    logic             hls_ready;
    logic [HUE_W-1:0] hue;
    logic [PCT_W-1:0] lightness;
    logic [PCT_W-1:0] saturation;

    logic             offer_typed;
    hls_t             offer_want;
    hls_t             pending_hls[$];
    hls_t             got_hls;
    hls_t             want_hls;
    pixel_row_t       directed_rows [NUM_DIRECTED];

    int               mismatches;
    int               hls_count;
    int               cycle_count;
    bit               steady_run;
    bit               held_off = 1'b0;
    int               ready_gap;

    logic [CH_W-1:0]  pr;
    logic [CH_W-1:0]  pg;
    logic [CH_W-1:0]  pb;
    logic [CH_W-1:0]  top;
    logic [CH_W-1:0]  low;
    int               kind;
    int               side;

    rgb_to_hls_integer_core uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .hls_valid   (hls_valid),
        .hls_ready   (hls_ready),
        .hue         (hue),
        .lightness   (lightness),
        .saturation  (saturation)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic int div_round(input int num, input int den);
        if (num >= 0)
            return (2 * num + den) / (2 * den);
        return -((2 * (-num) + den) / (2 * den));
    endfunction

    function automatic hls_t predict_hls(input logic [CH_W-1:0] r8, g8, b8);
        int   r;
        int   g;
        int   b;
        int   hi;
        int   lo;
        int   span;
        int   light;
        int   hue_deg;
        int   sat;
        int   sat_den;
        int   dev;
        hls_t res;
        r  = int'(r8);
        g  = int'(g8);
        b  = int'(b8);
        hi = r;
        lo = r;
        if (g > hi) hi = g;
        if (b > hi) hi = b;
        if (g < lo) lo = g;
        if (b < lo) lo = b;
        span = hi - lo;
        light = div_round((hi + lo) * 100, 510);
        if (light > int'(PCT_MAX))
            light = int'(PCT_MAX);
        if (span == 0)
        begin
            hue_deg = 0;
            sat     = 0;
        end
        else
        begin
            if (hi == r)
                hue_deg = div_round(60 * (g - b), span);
            else if (hi == g)
                hue_deg = div_round(60 * (b - r) + 120 * span, span);
            else
                hue_deg = div_round(60 * (r - g) + 240 * span, span);
            dev     = (2 * light - 100 < 0) ? (100 - 2 * light) : (2 * light - 100);
            sat_den = 100 - dev;
            if (sat_den <= 0)
                sat = int'(PCT_MAX);
            else
                sat = div_round(10000 * span, 255 * sat_den);
            if (sat > int'(PCT_MAX))
                sat = int'(PCT_MAX);
        end
        if (hue_deg < 0)
            hue_deg = hue_deg + int'(HUE_WRAP);
        if (hue_deg < 0)
            hue_deg = 0;
        if (hue_deg > int'(HUE_MAX))
            hue_deg = int'(HUE_MAX);
        res.hue        = HUE_W'(hue_deg);
        res.lightness  = PCT_W'(light);
        res.saturation = PCT_W'(sat);
        return res;
    endfunction

    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("%0t ns: %s", $time, msg);
    endtask

    task automatic send_pixel(input logic [CH_W-1:0] r, g, b, input logic typed,
                              input hls_t want, input int gap);
        if (gap > 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_valid <= 1'b1;
        red         <= r;
        green       <= g;
        blue        <= b;
        offer_typed <= typed;
        offer_want  <= want;
        do
            @(posedge clk);
        while (!pixel_ready);
    endtask

    // record each pixel transfer, then check each result transfer in order
    always @(posedge clk)
    begin
        if (rst_n && pixel_valid && pixel_ready)
            pending_hls.push_back(offer_typed ? offer_want : predict_hls(red, green, blue));
        if (rst_n && hls_valid && hls_ready)
        begin
            got_hls = '{hue, lightness, saturation};
            if (pending_hls.size() == 0)
                note_mismatch($sformatf("result #%0d with none pending: %0d %0d %0d",
                                        hls_count, hue, lightness, saturation));
            else
            begin
                want_hls = pending_hls.pop_front();
                if (got_hls.hue !== want_hls.hue)
                    note_mismatch($sformatf("result #%0d hue: got %0d expected %0d",
                                            hls_count, got_hls.hue, want_hls.hue));
                if (got_hls.lightness !== want_hls.lightness)
                    note_mismatch($sformatf("result #%0d lightness: got %0d expected %0d",
                                            hls_count, got_hls.lightness,
                                            want_hls.lightness));
                if (got_hls.saturation !== want_hls.saturation)
                    note_mismatch($sformatf("result #%0d saturation: got %0d expected %0d",
                                            hls_count, got_hls.saturation,
                                            want_hls.saturation));
            end
            hls_count++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("rgb_to_hls_integer_core test failed");
            $finish;
        end
    end

    initial
    begin
        hls_ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (!held_off && hls_count >= 300)
            begin
                held_off = 1'b1;
                hls_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            ready_gap = steady_run ? 0 : idle_len();
            if (ready_gap > 0)
            begin
                hls_ready <= 1'b0;
                repeat (ready_gap) @(posedge clk);
            end
            hls_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        pixel_valid = 1'b0;
        red         = '0;
        green       = '0;
        blue        = '0;
        offer_typed = PREDICTED;
        offer_want  = '0;
        mismatches  = 0;
        hls_count   = 0;
        cycle_count = 0;
        steady_run  = 1'b0;

        directed_rows = '{
            {8'd0,   8'd0,   8'd0,   KNOWN,     9'd0,   7'd0,   7'd0},
            {8'd255, 8'd255, 8'd255, KNOWN,     9'd0,   7'd100, 7'd0},
            {8'd128, 8'd128, 8'd128, KNOWN,     9'd0,   7'd50,  7'd0},
            {8'd255, 8'd0,   8'd0,   KNOWN,     9'd0,   7'd50,  7'd100},
            {8'd0,   8'd255, 8'd0,   KNOWN,     9'd120, 7'd50,  7'd100},
            {8'd0,   8'd0,   8'd255, KNOWN,     9'd240, 7'd50,  7'd100},
            {8'd255, 8'd255, 8'd0,   KNOWN,     9'd60,  7'd50,  7'd100},
            {8'd0,   8'd255, 8'd255, KNOWN,     9'd180, 7'd50,  7'd100},
            {8'd255, 8'd0,   8'd255, KNOWN,     9'd300, 7'd50,  7'd100},
            {8'd1,   8'd0,   8'd0,   KNOWN,     9'd0,   7'd0,   7'd100},
            {8'd255, 8'd255, 8'd253, KNOWN,     9'd60,  7'd100, 7'd100},
            {8'd6,   8'd0,   8'd0,   KNOWN,     9'd0,   7'd1,   7'd100},
            {8'd255, 8'd0,   8'd3,   KNOWN,     9'd359, 7'd50,  7'd100},
            {8'd0,   8'd0,   8'd1,   KNOWN,     9'd240, 7'd0,   7'd100},
            {8'd254, 8'd255, 8'd255, KNOWN,     9'd180, 7'd100, 7'd100},
            {8'd120, 8'd0,   8'd1,   PREDICTED, 9'd0,   7'd0,   7'd0},
            {8'd120, 8'd1,   8'd0,   PREDICTED, 9'd0,   7'd0,   7'd0},
            {8'd200, 8'd200, 8'd100, PREDICTED, 9'd0,   7'd0,   7'd0},
            {8'd100, 8'd200, 8'd200, PREDICTED, 9'd0,   7'd0,   7'd0},
            {8'd200, 8'd100, 8'd200, PREDICTED, 9'd0,   7'd0,   7'd0},
            {8'd0,   8'd128, 8'd255, PREDICTED, 9'd0,   7'd0,   7'd0},
            {8'd255, 8'd254, 8'd254, PREDICTED, 9'd0,   7'd0,   7'd0},
            {8'd1,   8'd1,   8'd0,   PREDICTED, 9'd0,   7'd0,   7'd0},
            {8'd170, 8'd85,  8'd0,   PREDICTED, 9'd0,   7'd0,   7'd0},
            {8'd86,  8'd171, 8'd255, PREDICTED, 9'd0,   7'd0,   7'd0}
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_pixel(directed_rows[i].r, directed_rows[i].g, directed_rows[i].b,
                       directed_rows[i].typed, directed_rows[i].want, idle_len());

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            steady_run = (i >= 1000 && i < 1200);
            if (i == 800)
            begin
                pixel_valid <= 1'b0;
                do
                    @(posedge clk);
                while (pending_hls.size() != 0);
            end
            pr   = 8'($urandom);
            pg   = 8'($urandom);
            pb   = 8'($urandom);
            kind = $urandom_range(0, 9);
            side = $urandom_range(0, 2);
            case (kind)
                4:
                begin
                    pg = pr;
                    pb = pr;
                end
                5:
                begin
                    top = 8'($urandom);
                    low = 8'($urandom_range(0, top));
                    pr  = (side == 2) ? low : top;
                    pg  = (side == 1) ? low : top;
                    pb  = (side == 0) ? low : top;
                end
                6:
                begin
                    pr = 8'($urandom_range(0, 6));
                    pg = 8'($urandom_range(0, 6));
                    pb = 8'($urandom_range(0, 6));
                end
                7:
                begin
                    pr = 8'($urandom_range(249, 255));
                    pg = 8'($urandom_range(249, 255));
                    pb = 8'($urandom_range(249, 255));
                end
                8:
                begin
                    pr = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    pg = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    pb = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                end
                9:
                begin
                    if (side == 0) pr = 8'hFF;
                    if (side == 1) pg = 8'hFF;
                    if (side == 2) pb = 8'hFF;
                end
                default:
                begin
                end
            endcase
            send_pixel(pr, pg, pb, PREDICTED, '0, steady_run ? 0 : idle_len());
        end
        steady_run = 1'b0;
        pixel_valid <= 1'b0;

        while (pending_hls.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("rgb_to_hls_integer_core test passed");
        else
            $display("rgb_to_hls_integer_core test failed");
        $finish;
    end

endmodule
